@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the ray/sphere intersection RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/rsi_pkg.sv @@
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared constants and types of the ray/sphere intersection pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int COORD_W_DEF = 32;
    localparam int FRAC_W_DEF  = 16;
    localparam int MAT_W       = 32;
    localparam int REG_W       = 64;
    localparam int NUM_REGS    = 6;
    localparam int IDX_W       = 3;
    localparam int DOT_W       = 64;
    localparam int SQ_W        = 128;
    localparam int ROOT_W      = 64;
    localparam int DIST_W      = 31;

    localparam logic [IDX_W-1:0] REG_ROW0_C01 = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW0_C23 = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW1_C01 = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROW1_C23 = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROW2_C01 = 3'd4;
    localparam logic [IDX_W-1:0] REG_ROW2_C23 = 3'd5;

    localparam logic [REG_W-1:0] RST_ROW0_C01 = 64'h0000_0000_0001_0000;
    localparam logic [REG_W-1:0] RST_ROW0_C23 = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] RST_ROW1_C01 = 64'h0001_0000_0000_0000;
    localparam logic [REG_W-1:0] RST_ROW1_C23 = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] RST_ROW2_C01 = 64'h0000_0000_0000_0000;
    localparam logic [REG_W-1:0] RST_ROW2_C23 = 64'h0000_0000_0001_0000;

    typedef struct packed {
        logic              miss;
        logic              hpos;
        logic [DOT_W-1:0]  habs;
        logic [DOT_W-1:0]  a;
    } t_side;

endpackage

@@ rtl/rsi_xform.sv @@
// ----------------------------------------------------------------------------
// rsi_xform
// Two-stage affine transform of the ray origin and direction into object space.
// ----------------------------------------------------------------------------
module rsi_xform #(
    parameter int CW = rsi_pkg::COORD_W_DEF,
    parameter int FW = rsi_pkg::FRAC_W_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [CW-1:0]         i_org [3],
    input  logic signed [CW-1:0]         i_dir [3],
    input  logic signed [rsi_pkg::MAT_W-1:0] i_mat [3][4],
    output logic                         o_valid,
    output logic signed [CW-1:0]         o_org [3],
    output logic signed [CW-1:0]         o_dir [3]
);
    import rsi_pkg::*;

    localparam int PW = MAT_W + CW;
    localparam int TW = MAT_W + FW;
    localparam int SW = ((PW > TW) ? PW : TW) + 3;
    localparam logic signed [SW-1:0] CMAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0] CMIN = ~CMAX;

    logic                  r_v1;
    logic                  r_v2;
    logic signed [PW-1:0]  r_po [3][3];
    logic signed [PW-1:0]  r_pd [3][3];
    logic signed [MAT_W-1:0] r_tr [3];
    logic signed [CW-1:0]  r_org [3];
    logic signed [CW-1:0]  r_dir [3];
    logic signed [CW-1:0]  n_org [3];
    logic signed [CW-1:0]  n_dir [3];

    function automatic logic signed [CW-1:0] clamp_shift(input logic signed [SW-1:0] acc);
        logic signed [SW-1:0] sh;
        sh = acc >>> FW;
        if (sh > CMAX) begin
            return CW'(CMAX);
        end else if (sh < CMIN) begin
            return CW'(CMIN);
        end
        return CW'(sh);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r_po[r][k] <= PW'(i_mat[r][k]) * PW'(i_org[k]);
                    r_pd[r][k] <= PW'(i_mat[r][k]) * PW'(i_dir[k]);
                end
                r_tr[r] <= i_mat[r][3];
            end
            r_org <= n_org;
            r_dir <= n_dir;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_org[r] = clamp_shift(SW'(r_po[r][0]) + SW'(r_po[r][1]) + SW'(r_po[r][2])
                                   + (SW'(r_tr[r]) <<< FW));
            n_dir[r] = clamp_shift(SW'(r_pd[r][0]) + SW'(r_pd[r][1]) + SW'(r_pd[r][2]));
        end
    end

    assign o_valid = r_v2;
    assign o_org   = r_org;
    assign o_dir   = r_dir;

endmodule

@@ rtl/rsi_quad.sv @@
// ----------------------------------------------------------------------------
// rsi_quad
// Dot products, quadratic coefficients and discriminant over six stages.
// ----------------------------------------------------------------------------
module rsi_quad #(
    parameter int CW = rsi_pkg::COORD_W_DEF,
    parameter int FW = rsi_pkg::FRAC_W_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic signed [CW-1:0]       i_org [3],
    input  logic signed [CW-1:0]       i_dir [3],
    output logic                       o_valid,
    output logic [rsi_pkg::SQ_W-1:0]   o_disc,
    output rsi_pkg::t_side             o_side
);
    import rsi_pkg::*;

    localparam int PW = 2 * CW;
    localparam int XW = ((PW + 2) > (DOT_W + 1)) ? (PW + 2) : (DOT_W + 1);
    localparam logic signed [XW-1:0] SMAX = {{(XW-DOT_W+1){1'b0}}, {(DOT_W-1){1'b1}}};
    localparam logic signed [XW-1:0] SMIN = ~SMAX + XW'(1);
    localparam logic signed [DOT_W-1:0] ONE = {{(DOT_W-FW-1){1'b0}}, 1'b1, {FW{1'b0}}};

    logic [5:0]              r_v;
    logic signed [PW-1:0]    r_dd [3];
    logic signed [PW-1:0]    r_do [3];
    logic signed [PW-1:0]    r_oo [3];
    logic signed [DOT_W-1:0] r_a;
    logic signed [DOT_W-1:0] r_h;
    logic signed [DOT_W-1:0] r_o2;
    t_side                   r_s5;
    t_side                   r_s6;
    t_side                   r_s7;
    t_side                   r_s8;
    logic                    r_cneg5;
    logic                    r_cneg6;
    logic                    r_cneg7;
    logic [DOT_W-1:0]        r_cmag;
    logic [63:0]             r_hll;
    logic [63:0]             r_hlh;
    logic [63:0]             r_hhh;
    logic [63:0]             r_all;
    logic [63:0]             r_alh;
    logic [63:0]             r_ahl;
    logic [63:0]             r_ahh;
    logic [SQ_W-1:0]         r_hsq;
    logic [SQ_W-1:0]         r_ac;
    logic [SQ_W-1:0]         r_disc;
    logic signed [DOT_W-1:0] n_c;

    function automatic logic signed [DOT_W-1:0] dot_sat(input logic signed [PW-1:0] p0,
                                                        input logic signed [PW-1:0] p1,
                                                        input logic signed [PW-1:0] p2);
        logic signed [XW-1:0] s;
        s = (XW'(p0) + XW'(p1) + XW'(p2)) >>> FW;
        if (s > SMAX) begin
            return DOT_W'(SMAX);
        end else if (s < SMIN) begin
            return DOT_W'(SMIN);
        end
        return DOT_W'(s);
    endfunction

    assign n_c = r_o2 - ONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_dd[k] <= PW'(i_dir[k]) * PW'(i_dir[k]);
                r_do[k] <= PW'(i_dir[k]) * PW'(i_org[k]);
                r_oo[k] <= PW'(i_org[k]) * PW'(i_org[k]);
            end
            r_a  <= dot_sat(r_dd[0], r_dd[1], r_dd[2]);
            r_h  <= dot_sat(r_do[0], r_do[1], r_do[2]);
            r_o2 <= dot_sat(r_oo[0], r_oo[1], r_oo[2]);

            r_s5.miss <= (r_a <= 0);
            r_s5.hpos <= (r_h > 0);
            r_s5.habs <= r_h[DOT_W-1] ? DOT_W'(-r_h) : DOT_W'(r_h);
            r_s5.a    <= DOT_W'(r_a);
            r_cneg5   <= n_c[DOT_W-1];
            r_cmag    <= n_c[DOT_W-1] ? DOT_W'(-n_c) : DOT_W'(n_c);

            r_s6    <= r_s5;
            r_cneg6 <= r_cneg5;
            r_hll   <= r_s5.habs[31:0] * r_s5.habs[31:0];
            r_hlh   <= r_s5.habs[31:0] * r_s5.habs[63:32];
            r_hhh   <= r_s5.habs[63:32] * r_s5.habs[63:32];
            r_all   <= r_s5.a[31:0] * r_cmag[31:0];
            r_alh   <= r_s5.a[31:0] * r_cmag[63:32];
            r_ahl   <= r_s5.a[63:32] * r_cmag[31:0];
            r_ahh   <= r_s5.a[63:32] * r_cmag[63:32];

            r_s7    <= r_s6;
            r_cneg7 <= r_cneg6;
            r_hsq   <= (SQ_W'(r_hhh) << 64) + (SQ_W'(r_hlh) << 33) + SQ_W'(r_hll);
            r_ac    <= (SQ_W'(r_ahh) << 64) + (SQ_W'(r_alh) << 32) + (SQ_W'(r_ahl) << 32)
                       + SQ_W'(r_all);

            r_s8.miss <= r_s7.miss | (!r_cneg7 && (r_hsq < r_ac));
            r_s8.hpos <= r_s7.hpos;
            r_s8.habs <= r_s7.habs;
            r_s8.a    <= r_s7.a;
            r_disc    <= r_cneg7 ? (r_hsq + r_ac) : (r_hsq - r_ac);
        end
    end

    assign o_valid = r_v[5];
    assign o_disc  = r_disc;
    assign o_side  = r_s8;

endmodule

@@ rtl/rsi_sqrt.sv @@
// ----------------------------------------------------------------------------
// rsi_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rsi_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [rsi_pkg::SQ_W-1:0]    i_disc,
    input  rsi_pkg::t_side              i_side,
    output logic                        o_valid,
    output logic [rsi_pkg::ROOT_W-1:0]  o_root,
    output rsi_pkg::t_side              o_side
);
    import rsi_pkg::*;

    localparam int NST = ROOT_W;
    localparam int RW  = ROOT_W + 3;

    logic              r_v    [NST];
    logic [RW-1:0]     r_rem  [NST];
    logic [ROOT_W-1:0] r_root [NST];
    logic [SQ_W-1:0]   r_rest [NST];
    t_side             r_side [NST];

    for (genvar g = 0; g < NST; g++) begin : g_stage
        logic              in_v;
        logic [RW-1:0]     in_rem;
        logic [ROOT_W-1:0] in_root;
        logic [SQ_W-1:0]   in_rest;
        t_side             in_side;
        logic [RW-1:0]     n_rem;
        logic [RW-1:0]     n_trial;

        if (g == 0) begin : g_first
            assign in_v    = i_valid;
            assign in_rem  = '0;
            assign in_root = '0;
            assign in_rest = i_disc;
            assign in_side = i_side;
        end else begin : g_next
            assign in_v    = r_v[g-1];
            assign in_rem  = r_rem[g-1];
            assign in_root = r_root[g-1];
            assign in_rest = r_rest[g-1];
            assign in_side = r_side[g-1];
        end

        assign n_rem   = {in_rem[RW-3:0], in_rest[SQ_W-1:SQ_W-2]};
        assign n_trial = RW'({in_root, 2'b01});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= in_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rest[g] <= in_rest << 2;
                r_side[g] <= in_side;
                if (n_rem >= n_trial) begin
                    r_rem[g]  <= n_rem - n_trial;
                    r_root[g] <= {in_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[g]  <= n_rem;
                    r_root[g] <= {in_root[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_root  = r_root[NST-1];
    assign o_side  = r_side[NST-1];

endmodule

@@ rtl/rsi_div.sv @@
// ----------------------------------------------------------------------------
// rsi_div
// Root selection and pipelined restoring division giving the hit distance.
// ----------------------------------------------------------------------------
module rsi_div #(
    parameter int FW = rsi_pkg::FRAC_W_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [rsi_pkg::ROOT_W-1:0]  i_root,
    input  rsi_pkg::t_side              i_side,
    output logic                        o_valid,
    output logic                        o_miss,
    output logic [rsi_pkg::DIST_W-1:0]  o_quot
);
    import rsi_pkg::*;

    localparam int NW   = ROOT_W + 1 + FW;
    localparam int AW   = DOT_W + DIST_W;
    localparam int CMPW = ((NW > AW) ? NW : AW) + 1;

    logic              r_vn;
    logic              r_missn;
    logic [DOT_W-1:0]  r_an;
    logic [NW-1:0]     r_num;
    logic [ROOT_W:0]   n_numer;
    logic              n_miss;

    logic              r_v    [DIST_W];
    logic              r_miss [DIST_W];
    logic [DOT_W-1:0]  r_a    [DIST_W];
    logic [CMPW-1:0]   r_rem  [DIST_W];
    logic [DIST_W-1:0] r_q    [DIST_W];

    always_comb begin
        n_miss = i_side.miss | (i_side.hpos && (i_side.habs > i_root));
        if (!i_side.hpos && (i_root <= i_side.habs)) begin
            n_numer = (ROOT_W + 1)'(i_side.habs - i_root);
        end else if (i_side.hpos) begin
            n_numer = (ROOT_W + 1)'(i_root - i_side.habs);
        end else begin
            n_numer = (ROOT_W + 1)'(i_root) + (ROOT_W + 1)'(i_side.habs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vn <= 1'b0;
        end else if (i_en) begin
            r_vn <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_missn <= n_miss;
            r_an    <= i_side.a;
            r_num   <= NW'(n_numer) << FW;
        end
    end

    for (genvar g = 0; g < DIST_W; g++) begin : g_stage
        localparam int B = DIST_W - 1 - g;
        logic              in_v;
        logic              in_miss;
        logic [DOT_W-1:0]  in_a;
        logic [CMPW-1:0]   in_rem;
        logic [DIST_W-1:0] in_q;
        logic [CMPW-1:0]   n_dv;

        if (g == 0) begin : g_first
            assign in_v    = r_vn;
            assign in_miss = r_missn;
            assign in_a    = r_an;
            assign in_rem  = CMPW'(r_num);
            assign in_q    = '0;
        end else begin : g_next
            assign in_v    = r_v[g-1];
            assign in_miss = r_miss[g-1];
            assign in_a    = r_a[g-1];
            assign in_rem  = r_rem[g-1];
            assign in_q    = r_q[g-1];
        end

        assign n_dv = CMPW'(in_a) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= in_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_miss[g] <= in_miss;
                r_a[g]    <= in_a;
                if (in_rem >= n_dv) begin
                    r_rem[g] <= in_rem - n_dv;
                    r_q[g]   <= in_q | (DIST_W'(1) << B);
                end else begin
                    r_rem[g] <= in_rem;
                    r_q[g]   <= in_q;
                end
            end
        end
    end

    assign o_valid = r_v[DIST_W-1];
    assign o_miss  = r_miss[DIST_W-1];
    assign o_quot  = r_q[DIST_W-1];

endmodule

@@ rtl/ray_sphere_intersect.sv @@
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// Ray against a unit sphere in object space, fully pipelined.
// ----------------------------------------------------------------------------
// Each request on the input channel carries one ray (origin and direction in
// signed fixed point). One result request (hit flag and distance) leaves per
// ray, in order. The user must write the inverse matrix through the plain
// write port only while no ray is in flight; the block does not enforce
// this. Reset loads the identity. One ray is accepted per clock while o_stall
// is low. A ray passes 2 transform stages, 6 dot product and discriminant
// stages, 64 square root stages (one root bit each), a root selection stage,
// 31 division stages (one quotient bit each) and the output register.
// The pipeline moves whenever its last stage is empty or the output register
// can take its result, so bubbles are squeezed out while the receiver stalls
// and a new ray is still accepted. Input stall rises only when a result waits
// in the last stage and the output register is held by a stall.
// Synchronous reset clears all valid bits and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ray_sphere_intersect #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_W_DEF,
    parameter int FRAC_BITS   = rsi_pkg::FRAC_W_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_origin_x,
    input  logic signed [COORD_WIDTH-1:0] i_origin_y,
    input  logic signed [COORD_WIDTH-1:0] i_origin_z,
    input  logic signed [COORD_WIDTH-1:0] i_dir_x,
    input  logic signed [COORD_WIDTH-1:0] i_dir_y,
    input  logic signed [COORD_WIDTH-1:0] i_dir_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_hit,
    output logic [rsi_pkg::DIST_W-1:0]    o_distance,
    input  logic                          i_cfg_we,
    input  logic [rsi_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [rsi_pkg::REG_W-1:0]     i_cfg_data
);
    import rsi_pkg::*;

    logic [REG_W-1:0]          r_cfg [NUM_REGS];
    logic signed [MAT_W-1:0]   w_mat [3][4];
    logic signed [COORD_WIDTH-1:0] w_org [3];
    logic signed [COORD_WIDTH-1:0] w_dir [3];
    logic signed [COORD_WIDTH-1:0] w_torg [3];
    logic signed [COORD_WIDTH-1:0] w_tdir [3];
    logic                      w_en;
    logic                      w_xv;
    logic                      w_qv;
    logic                      w_sv;
    logic                      w_dv;
    logic                      w_dmiss;
    logic [DIST_W-1:0]         w_quot;
    logic [SQ_W-1:0]           w_disc;
    logic [ROOT_W-1:0]         w_root;
    t_side                     w_qside;
    t_side                     w_sside;
    logic                      r_out_v;
    logic                      r_hit;
    logic [DIST_W-1:0]         r_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[0] <= RST_ROW0_C01;
            r_cfg[1] <= RST_ROW0_C23;
            r_cfg[2] <= RST_ROW1_C01;
            r_cfg[3] <= RST_ROW1_C23;
            r_cfg[4] <= RST_ROW2_C01;
            r_cfg[5] <= RST_ROW2_C23;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROW0_C01: r_cfg[0] <= i_cfg_data;
                REG_ROW0_C23: r_cfg[1] <= i_cfg_data;
                REG_ROW1_C01: r_cfg[2] <= i_cfg_data;
                REG_ROW1_C23: r_cfg[3] <= i_cfg_data;
                REG_ROW2_C01: r_cfg[4] <= i_cfg_data;
                REG_ROW2_C23: r_cfg[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 4; k++) begin
                if ((k % 2) == 1) begin
                    w_mat[r][k] = r_cfg[2 * r + k / 2][63:32];
                end else begin
                    w_mat[r][k] = r_cfg[2 * r + k / 2][31:0];
                end
            end
        end
    end

    assign w_org[0] = i_origin_x;
    assign w_org[1] = i_origin_y;
    assign w_org[2] = i_origin_z;
    assign w_dir[0] = i_dir_x;
    assign w_dir[1] = i_dir_y;
    assign w_dir[2] = i_dir_z;

    assign w_en    = !w_dv || !r_out_v || !i_stall;
    assign o_stall = !w_en;

    rsi_xform #(.CW(COORD_WIDTH), .FW(FRAC_BITS)) u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_org   (w_org),
        .i_dir   (w_dir),
        .i_mat   (w_mat),
        .o_valid (w_xv),
        .o_org   (w_torg),
        .o_dir   (w_tdir)
    );

    rsi_quad #(.CW(COORD_WIDTH), .FW(FRAC_BITS)) u_quad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_xv),
        .i_org   (w_torg),
        .i_dir   (w_tdir),
        .o_valid (w_qv),
        .o_disc  (w_disc),
        .o_side  (w_qside)
    );

    rsi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_qv),
        .i_disc  (w_disc),
        .i_side  (w_qside),
        .o_valid (w_sv),
        .o_root  (w_root),
        .o_side  (w_sside)
    );

    rsi_div #(.FW(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sv),
        .i_root  (w_root),
        .i_side  (w_sside),
        .o_valid (w_dv),
        .o_miss  (w_dmiss),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_hit   <= 1'b0;
            r_dist  <= '0;
        end else if (w_en && w_dv) begin
            r_out_v <= 1'b1;
            r_hit   <= !w_dmiss;
            r_dist  <= w_dmiss ? '0 : w_quot;
        end else if (!i_stall) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_valid    = r_out_v;
    assign o_hit      = r_hit;
    assign o_distance = r_dist;

    `ASSERT_ALWAYS(a_miss_zero_dist, i_clk, i_rst_n, !r_out_v || r_hit || (r_dist == '0))
    `ASSERT_ALWAYS(a_stall_only_when_full, i_clk, i_rst_n, !o_stall || (r_out_v && i_stall && w_dv))
    `ASSERT_NEXT(a_held_result_kept, i_clk, i_rst_n, r_out_v && i_stall, r_out_v)

endmodule
